[rtl/assert_macros.svh]
// Concurrent assertion helpers, clocked and reset-qualified.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF
`define ASSERT_CLK(lbl, clk, rstn, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
		else $error("assertion failed");
`define ASSERT_NEVER(lbl, clk, rstn, cond) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) \
		else $error("forbidden condition seen");
`else
`define ASSERT_CLK(lbl, clk, rstn, prop)
`define ASSERT_NEVER(lbl, clk, rstn, cond)
`endif

`endif

[rtl/lrubc_pkg.sv]
`default_nettype none
package lrubc_pkg;

	localparam int NUM_ENTRIES_DEF = 16;
	localparam int DEV_W           = 4;
	localparam int ADDR_W          = 32;
	localparam int TAG_W           = DEV_W + ADDR_W;
	localparam int SLOT_W          = 6;
	localparam int CNT_W           = 32;
	localparam int S_TDATA_W       = 40;
	localparam int M_TDATA_W       = 104;

	typedef enum logic [1:0] {
		OUTCOME_HIT   = 2'd0,
		OUTCOME_FILL  = 2'd1,
		OUTCOME_EVICT = 2'd2
	} outcome_t;

	typedef struct packed {
		logic scan_start;
		logic scan_en;
		logic sel_en;
		logic upd_en;
	} cmd_t;

	typedef struct packed {
		logic scan_done;
		logic out_free;
	} sts_t;

endpackage
`default_nettype wire

[rtl/lrubc_ctrl.sv]
`default_nettype none
module lrubc_ctrl (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  in_valid,
	output logic                 in_ready,
	input  wire lrubc_pkg::sts_t sts,
	output lrubc_pkg::cmd_t      cmd
);

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_SCAN = 4'b0010,
		ST_SEL  = 4'b0100,
		ST_UPD  = 4'b1000
	} state_t;

	state_t state_q;
	state_t state_d;

	always_comb begin
		state_d        = state_q;
		in_ready       = 1'b0;
		cmd.scan_start = 1'b0;
		cmd.scan_en    = 1'b0;
		cmd.sel_en     = 1'b0;
		cmd.upd_en     = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.scan_start = 1'b1;
					state_d        = ST_SCAN;
				end
			end
			ST_SCAN: begin
				cmd.scan_en = 1'b1;
				if (sts.scan_done) begin
					state_d = ST_SEL;
				end
			end
			ST_SEL: begin
				cmd.sel_en = 1'b1;
				state_d    = ST_UPD;
			end
			ST_UPD: begin
				if (sts.out_free) begin
					cmd.upd_en = 1'b1;
					state_d    = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule
`default_nettype wire

[rtl/lrubc_dp.sv]
`default_nettype none
`include "assert_macros.svh"
module lrubc_dp #(
	parameter int NUM_ENTRIES = lrubc_pkg::NUM_ENTRIES_DEF
) (
	input  wire                               clk,
	input  wire                               arst_n,
	input  wire  [lrubc_pkg::S_TDATA_W-1:0]   in_data,
	input  wire  lrubc_pkg::cmd_t             cmd,
	output lrubc_pkg::sts_t                   sts,
	output logic                              out_valid,
	input  wire                               out_ready,
	output logic [lrubc_pkg::M_TDATA_W-1:0]   out_data
);

	localparam int AW = (NUM_ENTRIES > 1) ? $clog2(NUM_ENTRIES) : 1;
	localparam int CW = $clog2(NUM_ENTRIES + 1);
	localparam int DW = lrubc_pkg::DEV_W;
	localparam int AD = lrubc_pkg::ADDR_W;
	localparam int TW = lrubc_pkg::TAG_W;
	localparam int KW = lrubc_pkg::CNT_W;

	logic [TW-1:0] tag_mem [NUM_ENTRIES];

	logic [DW-1:0] req_dev_q;
	logic [AD-1:0] req_addr_q;
	logic [CW-1:0] nvalid_q;
	logic [CW-1:0] cnt_q;
	logic [AW-1:0] rank_q [NUM_ENTRIES];

	logic [TW-1:0] rd_tag_s1;
	logic [AW-1:0] rd_idx_s1;
	logic          rd_vld_s1;

	logic          hit_q;
	logic [AW-1:0] hit_idx_q;

	logic                chosen_miss_q;
	logic [AW-1:0]       chosen_idx_q;
	logic [AW-1:0]       chosen_rank_q;
	lrubc_pkg::outcome_t outcome_q;

	logic [KW-1:0] hits_q;
	logic [KW-1:0] fills_q;
	logic [KW-1:0] evicts_q;

	logic                          out_valid_q;
	logic [lrubc_pkg::SLOT_W-1:0]  out_slot_q;
	lrubc_pkg::outcome_t           out_outcome_q;
	logic [KW-1:0]                 out_hits_q;
	logic [KW-1:0]                 out_fills_q;
	logic [KW-1:0]                 out_evicts_q;

	logic                issue;
	logic                full;
	logic                upd_fill;
	logic [AW-1:0]       lru_idx;
	logic [AW-1:0]       sel_idx;
	logic [AW-1:0]       sel_rank;
	lrubc_pkg::outcome_t sel_outcome;

	assign issue    = cmd.scan_en && !hit_q && (cnt_q != nvalid_q);
	assign full     = (nvalid_q == CW'(NUM_ENTRIES));
	assign upd_fill = cmd.upd_en && (outcome_q == lrubc_pkg::OUTCOME_FILL);

	assign sts.scan_done = hit_q || ((cnt_q == nvalid_q) && !rd_vld_s1);
	assign sts.out_free  = !out_valid_q || out_ready;

	always_comb begin
		lru_idx  = '0;
		sel_rank = '0;
		for (int e = 0; e < NUM_ENTRIES; e++) begin
			if (rank_q[e] == AW'(NUM_ENTRIES - 1)) begin
				lru_idx = lru_idx | AW'(e);
			end
		end
		if (hit_q) begin
			sel_outcome = lrubc_pkg::OUTCOME_HIT;
			sel_idx     = hit_idx_q;
		end else if (!full) begin
			sel_outcome = lrubc_pkg::OUTCOME_FILL;
			sel_idx     = nvalid_q[AW-1:0];
		end else begin
			sel_outcome = lrubc_pkg::OUTCOME_EVICT;
			sel_idx     = lru_idx;
		end
		for (int e = 0; e < NUM_ENTRIES; e++) begin
			if (sel_idx == AW'(e)) begin
				sel_rank = sel_rank | rank_q[e];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (issue) begin
			rd_tag_s1 <= tag_mem[cnt_q[AW-1:0]];
		end
		if (cmd.upd_en && chosen_miss_q) begin
			tag_mem[chosen_idx_q] <= {req_addr_q, req_dev_q};
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.scan_start) begin
			req_dev_q  <= in_data[DW-1:0];
			req_addr_q <= in_data[DW+AD-1:DW];
		end
		if (issue) begin
			rd_idx_s1 <= cnt_q[AW-1:0];
		end
		if (cmd.scan_en && rd_vld_s1 && !hit_q) begin
			hit_idx_q <= rd_idx_s1;
		end
		if (cmd.sel_en) begin
			chosen_miss_q <= !hit_q;
			chosen_idx_q  <= sel_idx;
			chosen_rank_q <= sel_rank;
			outcome_q     <= sel_outcome;
		end
		if (cmd.upd_en) begin
			out_slot_q    <= lrubc_pkg::SLOT_W'(chosen_idx_q);
			out_outcome_q <= outcome_q;
			out_hits_q    <= hits_q + KW'(outcome_q == lrubc_pkg::OUTCOME_HIT);
			out_fills_q   <= fills_q + KW'(outcome_q == lrubc_pkg::OUTCOME_FILL);
			out_evicts_q  <= evicts_q + KW'(outcome_q == lrubc_pkg::OUTCOME_EVICT);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			nvalid_q    <= '0;
			cnt_q       <= '0;
			rd_vld_s1   <= 1'b0;
			hit_q       <= 1'b0;
			hits_q      <= '0;
			fills_q     <= '0;
			evicts_q    <= '0;
			out_valid_q <= 1'b0;
			for (int e = 0; e < NUM_ENTRIES; e++) begin
				rank_q[e] <= AW'(e);
			end
		end else begin
			if (cmd.scan_start) begin
				cnt_q     <= '0;
				rd_vld_s1 <= 1'b0;
				hit_q     <= 1'b0;
			end else begin
				rd_vld_s1 <= issue;
				if (issue) begin
					cnt_q <= cnt_q + CW'(1);
				end
				if (cmd.scan_en && rd_vld_s1 && !hit_q &&
				    (rd_tag_s1 == {req_addr_q, req_dev_q})) begin
					hit_q <= 1'b1;
				end
			end
			if (cmd.upd_en) begin
				unique case (outcome_q)
					lrubc_pkg::OUTCOME_HIT:  hits_q   <= hits_q + KW'(1);
					lrubc_pkg::OUTCOME_FILL: begin
						fills_q  <= fills_q + KW'(1);
						nvalid_q <= nvalid_q + CW'(1);
					end
					lrubc_pkg::OUTCOME_EVICT: evicts_q <= evicts_q + KW'(1);
					default: hits_q <= hits_q;
				endcase
				for (int e = 0; e < NUM_ENTRIES; e++) begin
					if (chosen_idx_q == AW'(e)) begin
						rank_q[e] <= '0;
					end else if (rank_q[e] < chosen_rank_q) begin
						rank_q[e] <= rank_q[e] + AW'(1);
					end
				end
			end
			if (cmd.upd_en) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = {out_evicts_q, out_fills_q, out_hits_q, out_outcome_q, out_slot_q};

	`ASSERT_CLK(a_nvalid_bound, clk, arst_n, nvalid_q <= CW'(NUM_ENTRIES))
	`ASSERT_CLK(a_fill_grows, clk, arst_n, upd_fill |=> nvalid_q == $past(nvalid_q) + CW'(1))
	`ASSERT_CLK(a_upd_shows, clk, arst_n, cmd.upd_en |=> out_valid_q)
	`ASSERT_NEVER(a_hit_empty, clk, arst_n, hit_q && (nvalid_q == '0))

endmodule
`default_nettype wire

[rtl/lru_block_cache_tag_lookup_unit.sv]
// An accepted word passes through the tag scan, the select state and the update state, and its
// result then waits in the output register. The scan does one tag read a cycle over the nvalid
// filled entries (nvalid at most NUM_ENTRIES); a hit ends the scan early. A new word is accepted
// only after the update; a result not yet taken from the output register stalls the update.
// A finished result waits in the output register while the next word is accepted.
// Reset (arst_n low, asynchronous): all entries unused, recency order by index, counters zero.
`default_nettype none
module lru_block_cache_tag_lookup_unit #(
	parameter int NUM_ENTRIES = lrubc_pkg::NUM_ENTRIES_DEF
) (
	input  wire                               clk,
	input  wire                               arst_n,
	input  wire                               s_tvalid,
	output logic                              s_tready,
	// device_id[3:0], block_address[35:4], zero pad [39:36]
	input  wire  [lrubc_pkg::S_TDATA_W-1:0]   s_tdata,
	output logic                              m_tvalid,
	input  wire                               m_tready,
	// slot[5:0], outcome[7:6], hits_total[39:8], fills_total[71:40],
	// evictions_total[103:72]
	output logic [lrubc_pkg::M_TDATA_W-1:0]   m_tdata
);

	lrubc_pkg::cmd_t cmd;
	lrubc_pkg::sts_t sts;

	lrubc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	lrubc_dp #(
		.NUM_ENTRIES (NUM_ENTRIES)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_data   (s_tdata),
		.cmd       (cmd),
		.sts       (sts),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_data  (m_tdata)
	);

endmodule
`default_nettype wire

[tb/lru_block_cache_tag_lookup_unit_tb.sv]
`default_nettype none
module lru_block_cache_tag_lookup_unit_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int ENTRIES       = lrubc_pkg::NUM_ENTRIES_DEF;
	localparam int DEV_W         = lrubc_pkg::DEV_W;
	localparam int ADDR_W        = lrubc_pkg::ADDR_W;
	localparam int TAG_W         = lrubc_pkg::TAG_W;
	localparam int SLOT_W        = lrubc_pkg::SLOT_W;
	localparam int CNT_W         = lrubc_pkg::CNT_W;
	localparam int S_TDATA_W     = lrubc_pkg::S_TDATA_W;
	localparam int M_TDATA_W     = lrubc_pkg::M_TDATA_W;
	localparam int RANDOM_WORDS  = 2000;
	localparam int QUIET_WORDS   = 300;
	localparam int DRAIN_CYCLES  = ENTRIES + 24;
	localparam int STALL_LIMIT   = 1000;

	typedef struct packed {
		logic [CNT_W-1:0]    evictions;
		logic [CNT_W-1:0]    fills;
		logic [CNT_W-1:0]    hits;
		lrubc_pkg::outcome_t outcome;
		logic [SLOT_W-1:0]   slot;
	} lookup_t;

	typedef struct {
		logic [DEV_W-1:0]    dev;
		logic [ADDR_W-1:0]   addr;
		bit                  typed;
		logic [SLOT_W-1:0]   slot;
		lrubc_pkg::outcome_t outcome;
	} request_row_t;

	logic                 clk = 1'b0;
	logic                 arst_n;
	logic                 s_tvalid;
	logic                 s_tready;
	logic [S_TDATA_W-1:0] s_tdata;
	logic                 m_tvalid;
	logic                 m_tready;
	logic [M_TDATA_W-1:0] m_tdata;

	bit                   tag_valid [ENTRIES];
	logic [DEV_W-1:0]     tag_dev [ENTRIES];
	logic [ADDR_W-1:0]    tag_addr [ENTRIES];
	int                   recency [ENTRIES];
	logic [CNT_W-1:0]     hit_count;
	logic [CNT_W-1:0]     fill_count;
	logic [CNT_W-1:0]     evict_count;

	lookup_t              pending_lookups [$];
	int                   errors;
	bit                   quiet;
	bit                   busy;
	int                   idle_cycles;

	logic [DEV_W-1:0]     pool_dev [64];
	logic [ADDR_W-1:0]    pool_addr [64];

	request_row_t directed_rows [22] = '{
		'{4'd0,  32'h0000_0000, 1'b1, 6'd0,  lrubc_pkg::OUTCOME_FILL},
		'{4'd0,  32'h0000_0000, 1'b1, 6'd0,  lrubc_pkg::OUTCOME_HIT},
		'{4'd15, 32'hFFFF_FFFF, 1'b1, 6'd1,  lrubc_pkg::OUTCOME_FILL},
		'{4'd15, 32'hFFFF_FFFF, 1'b1, 6'd1,  lrubc_pkg::OUTCOME_HIT},
		'{4'd0,  32'hFFFF_FFFF, 1'b1, 6'd2,  lrubc_pkg::OUTCOME_FILL},
		'{4'd15, 32'h0000_0000, 1'b1, 6'd3,  lrubc_pkg::OUTCOME_FILL},
		'{4'd0,  32'h0000_0000, 1'b0, 6'd0,  lrubc_pkg::OUTCOME_HIT},
		'{4'd1,  32'h0000_0001, 1'b1, 6'd4,  lrubc_pkg::OUTCOME_FILL},
		'{4'd2,  32'h0000_0002, 1'b1, 6'd5,  lrubc_pkg::OUTCOME_FILL},
		'{4'd4,  32'h0000_0004, 1'b1, 6'd6,  lrubc_pkg::OUTCOME_FILL},
		'{4'd8,  32'h0000_0008, 1'b1, 6'd7,  lrubc_pkg::OUTCOME_FILL},
		'{4'd3,  32'h8000_0000, 1'b1, 6'd8,  lrubc_pkg::OUTCOME_FILL},
		'{4'd5,  32'h7FFF_FFFF, 1'b1, 6'd9,  lrubc_pkg::OUTCOME_FILL},
		'{4'd6,  32'h5555_5555, 1'b1, 6'd10, lrubc_pkg::OUTCOME_FILL},
		'{4'd7,  32'hAAAA_AAAA, 1'b1, 6'd11, lrubc_pkg::OUTCOME_FILL},
		'{4'd9,  32'h0000_FFFF, 1'b1, 6'd12, lrubc_pkg::OUTCOME_FILL},
		'{4'd10, 32'hFFFF_0000, 1'b1, 6'd13, lrubc_pkg::OUTCOME_FILL},
		'{4'd12, 32'h1234_5678, 1'b1, 6'd14, lrubc_pkg::OUTCOME_FILL},
		'{4'd14, 32'hDEAD_BEEF, 1'b1, 6'd15, lrubc_pkg::OUTCOME_FILL},
		'{4'd15, 32'hFFFF_FFFF, 1'b0, 6'd0,  lrubc_pkg::OUTCOME_HIT},
		'{4'd0,  32'h0000_0001, 1'b0, 6'd0,  lrubc_pkg::OUTCOME_HIT},
		'{4'd0,  32'hFFFF_FFFF, 1'b0, 6'd0,  lrubc_pkg::OUTCOME_HIT}
	};

	lru_block_cache_tag_lookup_unit u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	always #10 clk = ~clk;

	function automatic lookup_t tag_lookup(input logic [DEV_W-1:0] dev,
			input logic [ADDR_W-1:0] addr);
		int                  pos;
		int                  p;
		int                  e;
		lrubc_pkg::outcome_t oc;
		lookup_t             r;
		pos = ENTRIES - 1;
		oc = lrubc_pkg::OUTCOME_EVICT;
		for (p = 0; p < ENTRIES; p++) begin
			e = recency[p];
			if (tag_valid[e] && tag_dev[e] == dev && tag_addr[e] == addr) begin
				pos = p;
				oc = lrubc_pkg::OUTCOME_HIT;
				break;
			end
			if (!tag_valid[e]) begin
				pos = p;
				oc = lrubc_pkg::OUTCOME_FILL;
				break;
			end
		end
		e = recency[pos];
		if (oc == lrubc_pkg::OUTCOME_HIT) begin
			hit_count++;
		end else begin
			if (oc == lrubc_pkg::OUTCOME_FILL)
				fill_count++;
			else
				evict_count++;
			tag_valid[e] = 1'b1;
			tag_dev[e] = dev;
			tag_addr[e] = addr;
		end
		for (p = pos; p > 0; p--)
			recency[p] = recency[p-1];
		recency[0] = e;
		r.slot = SLOT_W'(e);
		r.outcome = oc;
		r.hits = hit_count;
		r.fills = fill_count;
		r.evictions = evict_count;
		return r;
	endfunction

	task automatic push_word(input logic [DEV_W-1:0] dev, input logic [ADDR_W-1:0] addr,
			input bit typed, input logic [SLOT_W-1:0] slot,
			input lrubc_pkg::outcome_t oc);
		lookup_t r;
		s_tdata <= {{(S_TDATA_W-TAG_W){1'b0}}, addr, dev};
		s_tvalid <= 1'b1;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		r = tag_lookup(dev, addr);
		if (typed) begin
			r.slot = slot;
			r.outcome = oc;
		end
		pending_lookups.push_back(r);
		if (!quiet && busy && $urandom_range(0, 3) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 13))
				@(posedge clk);
		end
	endtask

	initial begin
		int i;
		int k;
		int pool_size;
		logic [DEV_W-1:0] dev;
		logic [ADDR_W-1:0] addr;
		errors = 0;
		quiet = 1'b0;
		busy = 1'b1;
		arst_n <= 1'b0;
		s_tvalid <= 1'b0;
		s_tdata <= '0;
		for (i = 0; i < ENTRIES; i++) begin
			tag_valid[i] = 1'b0;
			tag_dev[i] = '0;
			tag_addr[i] = '0;
			recency[i] = i;
		end
		hit_count = '0;
		fill_count = '0;
		evict_count = '0;
		repeat (2)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (i = 0; i < $size(directed_rows); i++)
			push_word(directed_rows[i].dev, directed_rows[i].addr, directed_rows[i].typed,
				directed_rows[i].slot, directed_rows[i].outcome);

		pool_size = 1;
		for (i = 0; i < RANDOM_WORDS; i++) begin
			if (i % 150 == 0) begin
				pool_size = $urandom_range(8, 40);
				busy = $urandom_range(0, 2) != 0;
				for (k = 0; k < pool_size; k++) begin
					pool_dev[k] = DEV_W'($urandom_range(0, 15));
					pool_addr[k] = $urandom_range(0, 1) ? $urandom : $urandom_range(0, 7);
				end
			end
			quiet = i >= RANDOM_WORDS - QUIET_WORDS;
			if ($urandom_range(0, 3) != 0) begin
				k = $urandom_range(0, pool_size - 1);
				dev = pool_dev[k];
				addr = pool_addr[k];
			end else begin
				dev = DEV_W'($urandom_range(0, 15));
				addr = $urandom;
			end
			push_word(dev, addr, 1'b0, '0, lrubc_pkg::OUTCOME_HIT);
		end
		s_tvalid <= 1'b0;

		while (pending_lookups.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES)
			@(posedge clk);
		if (errors == 0)
			$display("lru_block_cache_tag_lookup_unit_tb passed");
		else
			$display("lru_block_cache_tag_lookup_unit_tb failed");
		$finish;
	end

	initial begin
		m_tready <= 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (quiet || !busy || $urandom_range(0, 3) != 0) begin
				m_tready <= 1'b1;
			end else begin
				m_tready <= 1'b0;
				repeat ($urandom_range(1, 13))
					@(posedge clk);
				m_tready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		lookup_t got;
		lookup_t want;
		if (arst_n && m_tvalid && m_tready) begin
			got = lookup_t'(m_tdata);
			if (pending_lookups.size() == 0) begin
				$display("%t unexpected word expected none actual %h", $time, m_tdata);
				errors++;
			end else begin
				want = pending_lookups.pop_front();
				if (got.slot !== want.slot) begin
					$display("%t slot expected %0d actual %0d", $time, want.slot, got.slot);
					errors++;
				end
				if (got.outcome !== want.outcome) begin
					$display("%t outcome expected %0d actual %0d", $time,
						want.outcome, got.outcome);
					errors++;
				end
				if (got.hits !== want.hits) begin
					$display("%t hits_total expected %0d actual %0d", $time,
						want.hits, got.hits);
					errors++;
				end
				if (got.fills !== want.fills) begin
					$display("%t fills_total expected %0d actual %0d", $time,
						want.fills, got.fills);
					errors++;
				end
				if (got.evictions !== want.evictions) begin
					$display("%t evictions_total expected %0d actual %0d", $time,
						want.evictions, got.evictions);
					errors++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= STALL_LIMIT) begin
			$display("lru_block_cache_tag_lookup_unit_tb failed");
			$finish;
		end
	end

	initial idle_cycles = 0;

endmodule
`default_nettype wire

[sim.f]
+incdir+rtl
rtl/lrubc_pkg.sv
rtl/lrubc_ctrl.sv
rtl/lrubc_dp.sv
rtl/lru_block_cache_tag_lookup_unit.sv
tb/lru_block_cache_tag_lookup_unit_tb.sv
